// ===== hdl/image_conv3x3_replicate_border_top_defines.svh =====
// ----------------------------------------------------------------------------
// image_conv3x3_replicate_border_top_defines
// assertion macros shared by the convolution block files
// ----------------------------------------------------------------------------
`ifndef IMAGE_CONV3X3_REPLICATE_BORDER_TOP_DEFINES_SVH
`define IMAGE_CONV3X3_REPLICATE_BORDER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, idle during reset
`define IC3RB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, idle during reset
`define IC3RB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/ic3rb_pkg.sv =====
// ----------------------------------------------------------------------------
// ic3rb_pkg
// widths, register indexes, reset values and shared types of the 3x3 filter
// ----------------------------------------------------------------------------
package ic3rb_pkg;

	localparam int PIX_W       = 8;
	localparam int WIDTH_REG_W = 11;
	localparam int HEIGHT_W    = 16;
	localparam int KERN_W      = 24;
	localparam int DIV_W       = 12;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;
	localparam int KSIZE       = 3;
	localparam int PROD_W      = 2 * PIX_W;
	// nine products of 255 * 255 fit in 20 bits
	localparam int SUM_W       = 20;
	// 2 * sum + divisor
	localparam int NUM_W       = SUM_W + 1;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOTTOM = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR       = 3'd5;

	// register reset values
	localparam logic [WIDTH_REG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0]    HEIGHT_RST = 16'd480;
	localparam logic [KERN_W-1:0]      KERN_RST   = 24'h010101;
	localparam logic [DIV_W-1:0]       DIV_RST    = 12'd9;

	// one window column, top pixel in the low byte
	typedef struct packed {
		logic [PIX_W-1:0] bot;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] top;
	} col_t;

	// kernel weights and divisor as seen by the arithmetic unit
	typedef struct packed {
		logic [KERN_W-1:0] top;
		logic [KERN_W-1:0] middle;
		logic [KERN_W-1:0] bottom;
		logic [DIV_W-1:0]  divisor;
	} kern_cfg_t;

	// request to the arithmetic unit
	typedef struct packed {
		logic start;
		col_t left;
		col_t mid;
		col_t right;
		logic run_end;
		logic image_end;
	} calc_req_t;

	// status and result of the arithmetic unit
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [PIX_W-1:0] pixel;
		logic             clamped;
		logic             run_end;
		logic             image_end;
	} calc_rsp_t;

endpackage

// ===== hdl/ic3rb_if.sv =====
// ----------------------------------------------------------------------------
// ic3rb_if
// valid/ready channels for pixel items and filtered results
// ----------------------------------------------------------------------------

// pixel or drain item
interface ic3rb_pix_if import ic3rb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [PIX_W-1:0] pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink (input valid, input req_type, input pixel_in, output ready);
endinterface

// filtered result
interface ic3rb_res_if import ic3rb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_out;
	logic             clamped;
	logic             run_end;
	logic             image_end;

	modport source (output valid, output pixel_out, output clamped, output run_end,
		output image_end, input ready);
	modport sink (input valid, input pixel_out, input clamped, input run_end,
		input image_end, output ready);
endinterface

// ===== hdl/image_conv3x3_replicate_border_top.sv =====
// ----------------------------------------------------------------------------
// image_conv3x3_replicate_border_top
// streaming 3x3 convolution with replicated borders over two row memories
// ----------------------------------------------------------------------------
//  channel  dir  signals                                      transfer
//  pix_ch   in   req_type, pixel_in                           valid & ready
//  res_ch   out  pixel_out, clamped, run_end, image_end       valid & ready
//  cfg      in   cfg_we, cfg_index, cfg_data                  cfg_we high
//
// one item at a time: a pixel yields no result, one result or two (last column);
// a drain item yields one; a saturated result skips the divider. the arithmetic is
// a shared multiply-accumulate (one column a cycle) and a restoring divider
// (one quotient bit a cycle).
// reset clears control, configuration and window; row memories and data registers are not reset.
// a finished result waits in the unit while the output register is still full.
// ----------------------------------------------------------------------------
`include "image_conv3x3_replicate_border_top_defines.svh"

module image_conv3x3_replicate_border_top import ic3rb_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ic3rb_pix_if.sink             pix_ch,
	ic3rb_res_if.source           res_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int EW = (AW + 1 > WIDTH_REG_W) ? AW + 1 : WIDTH_REG_W;
	localparam logic [AW:0]   MAXW_EXT = (AW + 1)'(MAX_WIDTH);
	localparam logic [AW-1:0] TOP_ADDR = AW'(MAX_WIDTH - 1);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_PIX_RD = 7'b0000010,
		ST_DR_RD0 = 7'b0000100,
		ST_DR_RD1 = 7'b0001000,
		ST_DR_RD2 = 7'b0010000,
		ST_CALC   = 7'b0100000,
		ST_START2 = 7'b1000000
	} state_t;

	// configuration
	logic [WIDTH_REG_W-1:0] image_width_q;
	logic [HEIGHT_W-1:0]    image_height_q;
	kern_cfg_t              kern_q;

	// sequencing state
	state_t               state_q;
	logic [AW-1:0]        col_q;
	logic [HEIGHT_W-1:0]  row_q;
	logic [AW-1:0]        drain_q;
	logic                 second_q;
	logic [PIX_W-1:0]     pix_q;
	logic [AW-1:0]        xm_q, xr_q;
	logic                 dlast_q;
	col_t                 dl_q, dm_q;
	col_t                 win_q [KSIZE];

	// row memories
	logic [PIX_W-1:0]     prev_mem  [MAX_WIDTH];
	logic [PIX_W-1:0]     older_mem [MAX_WIDTH];
	logic [PIX_W-1:0]     prev_rd_q, older_rd_q;
	logic [AW-1:0]        rd_addr;
	logic                 mem_we;

	// output register
	logic                 out_valid_q;
	logic [PIX_W-1:0]     out_pixel_q;
	logic                 out_clamped_q;
	logic                 out_run_end_q;
	logic                 out_image_end_q;
	logic                 out_load;

	// arithmetic unit
	calc_req_t            calc_req;
	calc_rsp_t            calc_rsp;

	logic                 pix_accept;
	logic [EW-1:0]        iw_ext, eff_w;
	logic [AW-1:0]        last_col;
	logic [HEIGHT_W-1:0]  h_eff;
	logic                 in_image;
	logic [AW-1:0]        ci;
	logic [AW-1:0]        d_cur, xl, xr;
	logic                 d_last;
	col_t                 new_col, rd_col;
	col_t                 win_next [KSIZE];
	logic                 first_col, last_pix, emit;

	// effective image size
	always_comb begin
		iw_ext = EW'(image_width_q);
		if (iw_ext < EW'(2)) begin
			eff_w = EW'(2);
		end else if (iw_ext > EW'(MAX_WIDTH)) begin
			eff_w = EW'(MAX_WIDTH);
		end else begin
			eff_w = iw_ext;
		end
		last_col = AW'(eff_w - EW'(1));
		h_eff    = (image_height_q < HEIGHT_W'(2)) ? HEIGHT_W'(2) : image_height_q;
		in_image = row_q < h_eff;
	end

	assign pix_ch.ready = state_q == ST_IDLE;
	assign pix_accept   = pix_ch.valid && pix_ch.ready;

	// store index of the current column
	assign ci = ({1'b0, col_q} >= MAXW_EXT) ? TOP_ADDR : col_q;

	// drain neighbor columns, left and right edges replicated
	always_comb begin
		d_cur  = (drain_q > last_col) ? last_col : drain_q;
		xl     = (d_cur == '0) ? '0 : d_cur - AW'(1);
		xr     = (d_cur < last_col) ? d_cur + AW'(1) : last_col;
		d_last = d_cur == last_col;
	end

	// new column and window for a pixel, left edge replicated
	always_comb begin
		new_col.top = (row_q >= HEIGHT_W'(2)) ? older_rd_q : prev_rd_q;
		new_col.mid = prev_rd_q;
		new_col.bot = pix_q;
		rd_col.top  = older_rd_q;
		rd_col.mid  = prev_rd_q;
		rd_col.bot  = prev_rd_q;
		first_col   = col_q == '0;
		last_pix    = col_q >= last_col;
		emit        = (row_q != '0) && !first_col;
		if (first_col) begin
			win_next[0] = new_col;
			win_next[1] = new_col;
		end else begin
			win_next[0] = win_q[1];
			win_next[1] = win_q[2];
		end
		win_next[2] = new_col;
	end

	// memory read address per state
	always_comb begin
		unique case (state_q)
			ST_IDLE:   rd_addr = pix_ch.req_type ? xl : ci;
			ST_DR_RD0: rd_addr = xm_q;
			ST_DR_RD1: rd_addr = xr_q;
			default:   rd_addr = ci;
		endcase
	end

	assign mem_we = state_q == ST_PIX_RD;

	// row memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			prev_mem[ci]  <= pix_q;
			older_mem[ci] <= prev_rd_q;
		end
		prev_rd_q  <= prev_mem[rd_addr];
		older_rd_q <= older_mem[rd_addr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RST;
			image_height_q <= HEIGHT_RST;
			kern_q.top     <= KERN_RST;
			kern_q.middle  <= KERN_RST;
			kern_q.bottom  <= KERN_RST;
			kern_q.divisor <= DIV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:   image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q <= cfg_data[HEIGHT_W-1:0];
				REG_KERNEL_TOP:    kern_q.top     <= cfg_data[KERN_W-1:0];
				REG_KERNEL_MIDDLE: kern_q.middle  <= cfg_data[KERN_W-1:0];
				REG_KERNEL_BOTTOM: kern_q.bottom  <= cfg_data[KERN_W-1:0];
				REG_DIVISOR:       kern_q.divisor <= cfg_data[DIV_W-1:0];
				default: ;
			endcase
		end
	end

	// item sequencer and image position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
			second_q <= 1'b0;
			for (int i = 0; i < KSIZE; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (pix_accept && !pix_ch.req_type && in_image) begin
						state_q <= ST_PIX_RD;
					end else if (pix_accept && pix_ch.req_type && !in_image) begin
						state_q <= ST_DR_RD0;
						if (d_last) begin
							drain_q <= '0;
							row_q   <= '0;
							col_q   <= '0;
						end else begin
							drain_q <= d_cur + AW'(1);
						end
					end
				end
				ST_PIX_RD: begin
					for (int i = 0; i < KSIZE; i++) begin
						win_q[i] <= win_next[i];
					end
					if (last_pix) begin
						col_q <= '0;
						row_q <= row_q + HEIGHT_W'(1);
					end else begin
						col_q <= col_q + AW'(1);
					end
					second_q <= emit && last_pix;
					state_q  <= emit ? ST_CALC : ST_IDLE;
				end
				ST_DR_RD0: state_q <= ST_DR_RD1;
				ST_DR_RD1: state_q <= ST_DR_RD2;
				ST_DR_RD2: state_q <= ST_CALC;
				ST_CALC: begin
					if (out_load) begin
						state_q <= second_q ? ST_START2 : ST_IDLE;
					end
				end
				ST_START2: begin
					second_q <= 1'b0;
					state_q  <= ST_CALC;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item payload and drain columns
	always_ff @(posedge clk) begin
		if (pix_accept) begin
			pix_q   <= pix_ch.pixel_in;
			xm_q    <= d_cur;
			xr_q    <= xr;
			dlast_q <= d_last;
		end
		if (state_q == ST_DR_RD0) begin
			dl_q <= rd_col;
		end
		if (state_q == ST_DR_RD1) begin
			dm_q <= rd_col;
		end
	end

	// request to the arithmetic unit
	always_comb begin
		calc_req.start     = 1'b0;
		calc_req.left      = win_next[0];
		calc_req.mid       = win_next[1];
		calc_req.right     = win_next[2];
		calc_req.run_end   = !last_pix;
		calc_req.image_end = 1'b0;
		unique case (state_q)
			ST_PIX_RD: begin
				calc_req.start = emit;
			end
			ST_START2: begin
				calc_req.start   = 1'b1;
				calc_req.left    = win_q[1];
				calc_req.mid     = win_q[2];
				calc_req.right   = win_q[2];
				calc_req.run_end = 1'b1;
			end
			ST_DR_RD2: begin
				calc_req.start     = 1'b1;
				calc_req.left      = dl_q;
				calc_req.mid       = dm_q;
				calc_req.right     = rd_col;
				calc_req.run_end   = 1'b1;
				calc_req.image_end = dlast_q;
			end
			default: ;
		endcase
	end

	ic3rb_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.kern   (kern_q),
		.req    (calc_req),
		.ack    (out_load),
		.rsp    (calc_rsp)
	);

	// output register, refilled in the cycle it is taken
	assign out_load = (state_q == ST_CALC) && calc_rsp.done
		&& (!out_valid_q || res_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_pixel_q     <= calc_rsp.pixel;
			out_clamped_q   <= calc_rsp.clamped;
			out_run_end_q   <= calc_rsp.run_end;
			out_image_end_q <= calc_rsp.image_end;
		end
	end

	assign res_ch.valid     = out_valid_q;
	assign res_ch.pixel_out = out_pixel_q;
	assign res_ch.clamped   = out_clamped_q;
	assign res_ch.run_end   = out_run_end_q;
	assign res_ch.image_end = out_image_end_q;

	`IC3RB_ASSERT_IMPL(a_start_free, calc_req.start, !calc_rsp.busy, "calc started while busy")
	`IC3RB_ASSERT_NEXT(a_pix_read, pix_accept && !pix_ch.req_type && in_image, state_q == ST_PIX_RD, "pixel not read")
	`IC3RB_ASSERT_IMPL(a_end_marks, res_ch.valid && res_ch.image_end, res_ch.run_end, "image end without run end")

endmodule

// ===== hdl/ic3rb_calc.sv =====
// ----------------------------------------------------------------------------
// ic3rb_calc
// weighted 3x3 sum, one column per cycle, then rounded division by restoring
// steps, one quotient bit per cycle, with saturation at 255
// ----------------------------------------------------------------------------
`include "image_conv3x3_replicate_border_top_defines.svh"

module ic3rb_calc import ic3rb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  kern_cfg_t kern,
	input  calc_req_t req,
	input  logic      ack,
	output calc_rsp_t rsp
);

	typedef enum logic [4:0] {
		C_IDLE = 5'b00001,
		C_MAC  = 5'b00010,
		C_PREP = 5'b00100,
		C_DIV  = 5'b01000,
		C_DONE = 5'b10000
	} calc_state_t;

	calc_state_t          state_q;
	col_t                 col_q [KSIZE];
	logic [1:0]           k_q;
	logic [SUM_W-1:0]     acc_q;
	logic [NUM_W-1:0]     rem_q;
	logic [DIV_W:0]       dbl_q;
	logic [2:0]           bit_q;
	logic [PIX_W-1:0]     quo_q;
	logic                 clamp_q;
	logic                 run_end_q;
	logic                 image_end_q;

	col_t                 cur;
	logic [PIX_W-1:0]     w_top, w_mid, w_bot;
	logic [PROD_W-1:0]    p_top, p_mid, p_bot;
	logic [SUM_W-1:0]     mac_sum;
	logic [DIV_W-1:0]     div_eff;
	logic [DIV_W:0]       dbl;
	logic [NUM_W-1:0]     num;
	logic [NUM_W-1:0]     prep_cap;
	logic [NUM_W-1:0]     div_cap;
	logic [NUM_W-1:0]     trial;
	logic                 fits;

	// one column of the window times its weight column
	assign cur   = col_q[k_q];
	assign w_top = kern.top[{k_q, 3'b000} +: PIX_W];
	assign w_mid = kern.middle[{k_q, 3'b000} +: PIX_W];
	assign w_bot = kern.bottom[{k_q, 3'b000} +: PIX_W];
	assign p_top = cur.top * w_top;
	assign p_mid = cur.mid * w_mid;
	assign p_bot = cur.bot * w_bot;
	assign mac_sum = acc_q + SUM_W'(p_top) + SUM_W'(p_mid) + SUM_W'(p_bot);

	// round half up: floor((2*sum + d) / (2*d)), zero divisor acts as one
	assign div_eff  = (kern.divisor == '0) ? DIV_W'(1) : kern.divisor;
	assign dbl      = {div_eff, 1'b0};
	assign num      = {acc_q, 1'b0} + NUM_W'(div_eff);
	assign prep_cap = {dbl, 8'd0};
	assign div_cap  = {dbl_q, 8'd0};

	// one restoring step
	assign trial = NUM_W'(dbl_q) << bit_q;
	assign fits  = rem_q >= trial;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (req.start) begin
						k_q     <= '0;
						state_q <= C_MAC;
					end
				end
				C_MAC: begin
					k_q <= k_q + 2'd1;
					if (k_q == 2'(KSIZE - 1)) begin
						state_q <= C_PREP;
					end
				end
				C_PREP: begin
					state_q <= (num >= prep_cap) ? C_DONE : C_DIV;
				end
				C_DIV: begin
					if (bit_q == '0) begin
						state_q <= C_DONE;
					end
				end
				C_DONE: begin
					if (ack) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && req.start) begin
			col_q[0]    <= req.left;
			col_q[1]    <= req.mid;
			col_q[2]    <= req.right;
			run_end_q   <= req.run_end;
			image_end_q <= req.image_end;
			acc_q       <= '0;
		end
		if (state_q == C_MAC) begin
			acc_q <= mac_sum;
		end
		if (state_q == C_PREP) begin
			rem_q   <= num;
			dbl_q   <= dbl;
			bit_q   <= 3'd7;
			quo_q   <= '0;
			clamp_q <= num >= prep_cap;
		end
		if (state_q == C_DIV) begin
			if (fits) begin
				rem_q        <= rem_q - trial;
				quo_q[bit_q] <= 1'b1;
			end
			bit_q <= bit_q - 3'd1;
		end
	end

	// result view
	always_comb begin
		rsp.busy      = state_q != C_IDLE;
		rsp.done      = state_q == C_DONE;
		rsp.pixel     = clamp_q ? {PIX_W{1'b1}} : quo_q;
		rsp.clamped   = clamp_q;
		rsp.run_end   = run_end_q;
		rsp.image_end = image_end_q;
	end

	`IC3RB_ASSERT_NEXT(a_done_hold, rsp.done && !ack, rsp.done, "result dropped before ack")
	`IC3RB_ASSERT_IMPL(a_clamp_sat, rsp.done && rsp.clamped, rsp.pixel == 8'hFF, "clamp not saturated")
	`IC3RB_ASSERT_IMPL(a_rem_bound, state_q == C_DIV, rem_q < div_cap, "remainder out of range")

endmodule

// ===== tb/tb_image_conv3x3_replicate_border_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_conv3x3_replicate_border_top
// self-checking bench for the streaming 3x3 replicated-border filter
// ----------------------------------------------------------------------------
// every accepted pixel or drain transfer goes through a software copy of the
// filter held in a scoreboard class; filtered results are compared field by
// field, in order. short directed images cover the borders, rounding,
// saturation, drain and size-register corner cases; a tall image exercises
// the height register; random small images with random kernels follow, with
// random idling on both channels and one long hold-off on the result channel.
// ----------------------------------------------------------------------------
module tb_image_conv3x3_replicate_border_top;
	import ic3rb_pkg::*;

	localparam int MAX_W        = 1024;
	localparam int RANDOM_ITEMS = 500;
	localparam int SETTLE       = 64;
	localparam int HOLD_CYCLES  = 400;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PRINT_LIMIT  = 100;

	typedef enum logic {ITEM_PIXEL = 1'b0, ITEM_DRAIN = 1'b1} item_kind_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             clamped;
		logic             run_end;
		logic             image_end;
	} filt_res_t;

	typedef struct packed {
		logic [WIDTH_REG_W-1:0] width;
		logic [HEIGHT_W-1:0]    height;
		logic [KERN_W-1:0]      k_top;
		logic [KERN_W-1:0]      k_mid;
		logic [KERN_W-1:0]      k_bot;
		logic [DIV_W-1:0]       divisor;
	} filt_setup_t;

	// software copy of the filter plus the queue of filtered pixels still due
	class conv_scoreboard;
		logic [WIDTH_REG_W-1:0] width_reg;
		logic [HEIGHT_W-1:0]    height_reg;
		logic [KERN_W-1:0]      kern [KSIZE];
		logic [DIV_W-1:0]       div_reg;
		logic [PIX_W-1:0]       prev_line [MAX_W];
		logic [PIX_W-1:0]       older_line [MAX_W];
		col_t                   window [KSIZE];
		int unsigned            col_pos, row_pos, drain_pos;
		filt_res_t              expected_pixels [$];
		int unsigned            errors, n_items, n_ignored, n_checked, n_clamped, n_images;

		function new();
			width_reg  = WIDTH_RST;
			height_reg = HEIGHT_RST;
			kern[0]    = KERN_RST;
			kern[1]    = KERN_RST;
			kern[2]    = KERN_RST;
			div_reg    = DIV_RST;
			foreach (prev_line[i]) begin
				prev_line[i]  = '0;
				older_line[i] = '0;
			end
			foreach (window[i]) window[i] = '0;
			col_pos   = 0;
			row_pos   = 0;
			drain_pos = 0;
			errors    = 0;
			n_items   = 0;
			n_ignored = 0;
			n_checked = 0;
			n_clamped = 0;
			n_images  = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_IMAGE_WIDTH:   width_reg  = data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT:  height_reg = data[HEIGHT_W-1:0];
				REG_KERNEL_TOP:    kern[0]    = data[KERN_W-1:0];
				REG_KERNEL_MIDDLE: kern[1]    = data[KERN_W-1:0];
				REG_KERNEL_BOTTOM: kern[2]    = data[KERN_W-1:0];
				REG_DIVISOR:       div_reg    = data[DIV_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned eff_width();
			if (width_reg < 2) return 2;
			if (width_reg > MAX_W) return MAX_W;
			return width_reg;
		endfunction

		function int unsigned eff_height();
			return height_reg < 2 ? 2 : height_reg;
		endfunction

		function int unsigned clip_col(int unsigned i);
			return i >= MAX_W ? MAX_W - 1 : i;
		endfunction

		// last row stands in as its own bottom neighbor while draining
		function col_t last_row_column(int unsigned x);
			col_t c;
			c.top = older_line[x];
			c.mid = prev_line[x];
			c.bot = prev_line[x];
			return c;
		endfunction

		// weighted sum over three columns, divide rounding half up, clamp
		function filt_res_t filter_window(col_t l, col_t m, col_t r, logic run_end,
			logic image_end);
			col_t        cols [KSIZE];
			int unsigned acc, d, q, k;
			filt_res_t   res_item;
			cols[0] = l;
			cols[1] = m;
			cols[2] = r;
			acc = 0;
			for (k = 0; k < KSIZE; k++) begin
				acc += {24'd0, cols[k].top} * {24'd0, kern[0][8*k +: 8]};
				acc += {24'd0, cols[k].mid} * {24'd0, kern[1][8*k +: 8]};
				acc += {24'd0, cols[k].bot} * {24'd0, kern[2][8*k +: 8]};
			end
			d = div_reg == 0 ? 1 : div_reg;
			q = (2 * acc + d) / (2 * d);
			res_item.pixel     = q > 255 ? 8'hFF : q[7:0];
			res_item.clamped   = q > 255;
			res_item.run_end   = run_end;
			res_item.image_end = image_end;
			return res_item;
		endfunction

		// advance the filter by one accepted transfer, queue what it yields
		function void note_item(item_kind_t kind, logic [PIX_W-1:0] pix);
			int unsigned      w, h, r, c, ci, d;
			logic [PIX_W-1:0] mid, top;
			col_t             fresh;
			logic             last;
			w = eff_width();
			h = eff_height();
			r = row_pos;
			n_items++;
			if (kind == ITEM_PIXEL) begin
				// pixels after the last row are dropped
				if (r >= h) begin
					n_ignored++;
					return;
				end
				c  = col_pos;
				ci = clip_col(c);
				mid = prev_line[ci];
				top = r >= 2 ? older_line[ci] : mid;
				fresh.top = top;
				fresh.mid = mid;
				fresh.bot = pix;
				older_line[ci] = mid;
				prev_line[ci]  = pix;
				// left edge fills the whole window with the first column
				if (c == 0) begin
					window[0] = fresh;
					window[1] = fresh;
					window[2] = fresh;
				end else begin
					window[0] = window[1];
					window[1] = window[2];
					window[2] = fresh;
				end
				last = c >= w - 1;
				if (r >= 1 && c >= 1) begin
					expected_pixels.push_back(filter_window(window[0], window[1], window[2],
						!last, 1'b0));
					// right edge reuses the rightmost column
					if (last)
						expected_pixels.push_back(filter_window(window[1], window[2], window[2],
							1'b1, 1'b0));
				end
				if (last) begin
					col_pos = 0;
					row_pos = (r + 1) & 32'hFFFF;
				end else begin
					col_pos = (c + 1) & 32'h3FF;
				end
			end else begin
				// drain before the image is complete is dropped
				if (r < h) begin
					n_ignored++;
					return;
				end
				d = drain_pos > w - 1 ? w - 1 : drain_pos;
				last = d >= w - 1;
				expected_pixels.push_back(filter_window(
					last_row_column(clip_col(d == 0 ? 0 : d - 1)),
					last_row_column(clip_col(d)),
					last_row_column(clip_col(d + 1 < w ? d + 1 : w - 1)),
					1'b1, last));
				if (last) begin
					drain_pos = 0;
					row_pos   = 0;
					col_pos   = 0;
				end else begin
					drain_pos = (d + 1) & 32'h3FF;
				end
			end
		endfunction

		task report(string msg);
			if (errors < PRINT_LIMIT)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_pixel(filt_res_t got);
			filt_res_t want;
			if (expected_pixels.size() == 0) begin
				report($sformatf("result with nothing due: pixel_out %0d clamped %0b run_end %0b image_end %0b",
					got.pixel, got.clamped, got.run_end, got.image_end));
				return;
			end
			want = expected_pixels.pop_front();
			n_checked++;
			if (want.clamped) n_clamped++;
			if (want.image_end) n_images++;
			if (got.pixel !== want.pixel)
				report($sformatf("result %0d pixel_out %0d, expected %0d", n_checked,
					got.pixel, want.pixel));
			if (got.clamped !== want.clamped)
				report($sformatf("result %0d clamped %0b, expected %0b", n_checked,
					got.clamped, want.clamped));
			if (got.run_end !== want.run_end)
				report($sformatf("result %0d run_end %0b, expected %0b", n_checked,
					got.run_end, want.run_end));
			if (got.image_end !== want.image_end)
				report($sformatf("result %0d image_end %0b, expected %0b", n_checked,
					got.image_end, want.image_end));
		endtask

		task report_leftover();
			filt_res_t want;
			while (expected_pixels.size() != 0) begin
				want = expected_pixels.pop_front();
				report($sformatf("filtered pixel %0d never arrived (run_end %0b image_end %0b)",
					want.pixel, want.run_end, want.image_end));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ic3rb_pix_if pix ();
	ic3rb_res_if res ();

	conv_scoreboard sb;
	bit             src_idle_en;
	bit             snk_idle_en;
	bit             hold_off_req;
	int unsigned    random_items;

	image_conv3x3_replicate_border_top #(.MAX_WIDTH(MAX_W)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_ch    (pix),
		.res_ch    (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// input transfer monitor
	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready)
			sb.note_item(item_kind_t'(pix.req_type), pix.pixel_in);
	end

	// result transfer monitor
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			sb.check_pixel({res.pixel_out, res.clamped, res.run_end, res.image_end});
	end

	// result receiver: random stalls, one long hold-off on request
	initial begin : receiver
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				res.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res.ready <= !(snk_idle_en && $urandom_range(0, 99) < 10);
		end
	end

	// watchdog on cycles without any transfer
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((pix.valid && pix.ready) || (res.valid && res.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL image_conv3x3_replicate_border_top");
		$finish;
	end

	function automatic logic [PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [KERN_W-1:0] random_kernel();
		case ($urandom_range(0, 3))
			0: return '1;
			1: return {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
				8'($urandom_range(0, 3))};
			default: return 24'($urandom);
		endcase
	endfunction

	// random image size and kernel; divisor mostly the weight sum
	function automatic filt_setup_t random_setup(bit wide);
		filt_setup_t s;
		int unsigned pick, wsum, k;
		pick = $urandom_range(0, 9);
		if (wide)
			s.width = 11'($urandom_range(16, 32));
		else if (pick == 0)
			s.width = 11'($urandom_range(0, 1));
		else if (pick == 1)
			s.width = 11'($urandom_range(13, 40));
		else
			s.width = 11'($urandom_range(2, 12));
		s.height = $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 1)) :
			16'($urandom_range(2, 5));
		s.k_top = random_kernel();
		s.k_mid = random_kernel();
		s.k_bot = random_kernel();
		wsum = 0;
		for (k = 0; k < KSIZE; k++)
			wsum += s.k_top[8*k +: 8] + s.k_mid[8*k +: 8] + s.k_bot[8*k +: 8];
		s.divisor = $urandom_range(0, 9) < 7 ? 12'(wsum) : 12'($urandom);
		return s;
	endfunction

	// one transfer on the pixel channel, with random gaps before it
	task automatic send_item(item_kind_t kind, logic [PIX_W-1:0] value);
		while (src_idle_en && $urandom_range(0, 99) < 10) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid    <= 1'b1;
		pix.req_type <= kind;
		pix.pixel_in <= value;
		@(posedge clk);
		while (!pix.ready) @(posedge clk);
	endtask

	// full rows of random pixels, with the odd early drain thrown in
	task automatic send_rows(int unsigned w, int unsigned rows, bit noisy);
		int unsigned r, c;
		for (r = 0; r < rows; r++) begin
			for (c = 0; c < w; c++) begin
				if (noisy && $urandom_range(0, 19) == 0)
					send_item(ITEM_DRAIN, random_pixel());
				send_item(ITEM_PIXEL, random_pixel());
				random_items++;
			end
		end
	endtask

	// drain of the last row, with the odd stray pixel thrown in
	task automatic send_drain(int unsigned w, bit noisy);
		int unsigned c;
		for (c = 0; c < w; c++) begin
			if (noisy && $urandom_range(0, 19) == 0)
				send_item(ITEM_PIXEL, random_pixel());
			send_item(ITEM_DRAIN, random_pixel());
			random_items++;
		end
	endtask

	// stop offering, let every due result arrive, then let the block settle
	task automatic wait_idle();
		int unsigned n;
		pix.valid <= 1'b0;
		n = 0;
		while (sb.expected_pixels.size() != 0 && n < QUIET_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.set_register(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setup(filt_setup_t s);
		set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(s.width));
		set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(s.height));
		set_reg(REG_KERNEL_TOP, s.k_top);
		set_reg(REG_KERNEL_MIDDLE, s.k_mid);
		set_reg(REG_KERNEL_BOTTOM, s.k_bot);
		set_reg(REG_DIVISOR, CFG_DATA_W'(s.divisor));
	endtask

	initial begin : stimulus
		filt_setup_t      s;
		logic [PIX_W-1:0] ramp [10];
		int unsigned      imgs;
		sb = new();
		arst_n       <= 1'b0;
		pix.valid    <= 1'b0;
		pix.req_type <= ITEM_PIXEL;
		pix.pixel_in <= '0;
		cfg_we       <= 1'b0;
		cfg_index    <= REG_IMAGE_WIDTH;
		cfg_data     <= '0;
		src_idle_en  = 1'b1;
		snk_idle_en  = 1'b1;
		hold_off_req = 1'b0;
		random_items = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 2x2 image from undersized registers, all weights 255, divisor zero
		s = '{width: 11'd1, height: 16'd0, k_top: '1, k_mid: '1, k_bot: '1, divisor: '0};
		apply_setup(s);
		send_item(ITEM_DRAIN, 8'h5A);     // drain before the image is complete
		send_item(ITEM_PIXEL, 8'h00);
		send_item(ITEM_PIXEL, 8'hFF);
		send_item(ITEM_PIXEL, 8'hFF);
		send_item(ITEM_PIXEL, 8'h00);
		send_item(ITEM_PIXEL, 8'hA5);     // pixel while draining
		send_item(ITEM_DRAIN, 8'hFF);
		send_item(ITEM_DRAIN, 8'h00);
		wait_idle();

		// center tap only, divisor 2: odd pixels land on half and round up;
		// width shrinks from 6 to 3 in the middle of row 1
		s = '{width: 11'd6, height: 16'd3, k_top: '0, k_mid: 24'h000100, k_bot: '0,
			divisor: 12'd2};
		apply_setup(s);
		ramp = '{8'd1, 8'd3, 8'd5, 8'd255, 8'd254, 8'd0, 8'd7, 8'd9, 8'd11, 8'd127};
		foreach (ramp[i]) send_item(ITEM_PIXEL, ramp[i]);
		wait_idle();
		set_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		send_item(ITEM_PIXEL, 8'd201);
		send_rows(3, 1, 1'b0);
		send_drain(3, 1'b0);
		wait_idle();

		// tallest height register, cut short once three rows are in
		s = '{width: 11'd2, height: '1, k_top: random_kernel(), k_mid: random_kernel(),
			k_bot: random_kernel(), divisor: 12'($urandom)};
		apply_setup(s);
		send_rows(2, 3, 1'b0);
		wait_idle();
		set_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(4));
		send_rows(2, 1, 1'b0);
		send_drain(2, 1'b0);
		wait_idle();

		// random images; the first runs into the long result hold-off,
		// a few in the middle run with no idling at all
		random_items = 0;
		imgs = 0;
		while (random_items < RANDOM_ITEMS) begin
			s = random_setup(imgs == 0);
			src_idle_en = !(imgs >= 3 && imgs < 6);
			snk_idle_en = src_idle_en;
			apply_setup(s);
			if (imgs == 0) hold_off_req = 1'b1;
			send_rows(sb.eff_width(), sb.eff_height(), 1'b1);
			send_drain(sb.eff_width(), 1'b1);
			wait_idle();
			imgs++;
		end

		sb.report_leftover();
		$display("covered %0d input transfers (%0d dropped as out of place), %0d checked",
			sb.n_items, sb.n_ignored, sb.n_checked);
		$display("%0d saturated, %0d images, %0d random; widths 2..40, tall height register",
			sb.n_clamped, sb.n_images, imgs);
		if (sb.errors == 0)
			$display("PASS image_conv3x3_replicate_border_top");
		else
			$display("FAIL image_conv3x3_replicate_border_top");
		$finish;
	end

endmodule
